[hdl/dsr_pkg.sv]
// ----------------------------------------------------------------------------
// dsr_pkg: shared types and constants of the duty slew ramp
// Field widths, register indexes and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dsr_pkg;

  localparam int DUTY_W  = 16;
  localparam int TIME_W  = 26;
  localparam int ELAP_W  = 20;
  localparam int DT_W    = 17;
  localparam int PROD_W  = DUTY_W + DT_W;
  localparam int CNT_W   = $clog2(PROD_W + 1);
  localparam int IDX_W   = 2;

  localparam logic [DT_W-1:0] DT_LIMIT = DT_W'(100000);

  localparam logic [IDX_W-1:0] REG_MAX_DUTY  = 2'd0;
  localparam logic [IDX_W-1:0] REG_RISE_TIME = 2'd1;
  localparam logic [IDX_W-1:0] REG_FALL_TIME = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[hdl/dsr_divider.sv]
// ----------------------------------------------------------------------------
// dsr_divider: restoring divider, one quotient bit per cycle
// Divides the duty-time product by the ramp time.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_divider
  import dsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic      [PROD_W-1:0] quotient,
  output div_stat_t              stat
);

  logic [PROD_W-1:0] work;
  logic [TIME_W:0]   rem;
  logic [CNT_W-1:0]  count;
  logic              done;

  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem[TIME_W-1:0], work[PROD_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(PROD_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (count != '0) begin
      work <= {work[PROD_W-2:0], fits};
      rem  <= fits ? rem_sub : rem_sh;
    end
  end

  assign quotient  = work;
  assign stat.busy = count != '0;
  assign stat.done = done;

endmodule

`default_nettype wire

[hdl/duty_slew_ramp.sv]
// ----------------------------------------------------------------------------
// duty_slew_ramp: duty-cycle slew-rate limiter
// Loads a clamped target and steps the applied duty toward it by at most
// max_duty*dt/ramp_time per word.
//
//   channel  direction  signals                          content
//   s_       in         s_tvalid s_tready s_tdata s_tuser target, elapsed, load
//   m_       out        m_tvalid m_tready m_tdata         applied duty
//   cfg_     in         cfg_valid cfg_ready cfg_index cfg_data  registers
//
// An input word passes through accept, multiply, divider start, the wait on the
// bit-serial divider until it is seen to finish, and an update state that
// writes the new applied duty.
// A word with zero elapsed time or a zero ramp time skips the divider.
// The result register holds a word until taken; the next input word is
// accepted meanwhile and waits in its update cycle if the result is unread.
// Reset loads max_duty with all ones and clears the rest of the control state, not the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module duty_slew_ramp
  import dsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [39:0]       s_tdata,   // target_duty[15:0], elapsed_us[35:16], [39:36] ignored
  input  wire logic              s_tuser,   // load_target
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [15:0]       m_tdata,   // applied_duty[15:0]
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [TIME_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;

  logic [2:0]        state;
  logic [DUTY_W-1:0] max_duty;
  logic [TIME_W-1:0] rise_time;
  logic [TIME_W-1:0] fall_time;
  logic [DUTY_W-1:0] target_level;
  logic [DUTY_W-1:0] applied_level;
  logic [DT_W-1:0]   dt;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] ramp;
  logic              rising;
  logic              full_step;
  logic              hold;

  logic [DUTY_W-1:0] in_target;
  logic [ELAP_W-1:0] in_elapsed;
  logic [TIME_W-1:0] ramp_sel;
  logic              rising_now;
  logic [PROD_W-1:0] quotient;
  div_stat_t         div_stat;
  logic              div_start;
  logic [DUTY_W-1:0] diff;
  logic [DUTY_W-1:0] step_lo;
  logic              step_big;
  logic [DUTY_W-1:0] move;
  logic [DUTY_W-1:0] applied_next;
  logic              out_free;

  assign in_target  = s_tdata[15:0];
  assign in_elapsed = s_tdata[35:16];
  assign s_tready   = state == ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_free   = !m_tvalid || m_tready;
  assign div_start  = state == ST_START;

  assign rising_now = target_level > applied_level;
  assign ramp_sel   = rising_now ? rise_time : fall_time;

  dsr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (ramp),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    diff = rising ? target_level - applied_level : applied_level - target_level;
    if (hold) begin
      step_lo  = '0;
      step_big = 1'b0;
    end else if (full_step) begin
      step_lo  = max_duty;
      step_big = 1'b0;
    end else begin
      step_lo  = quotient[DUTY_W-1:0];
      step_big = |quotient[PROD_W-1:DUTY_W];
    end
    move         = (step_big || diff < step_lo) ? diff : step_lo;
    applied_next = rising ? applied_level + move : applied_level - move;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty  <= '1;
      rise_time <= '0;
      fall_time <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_DUTY:  max_duty  <= cfg_data[DUTY_W-1:0];
        REG_RISE_TIME: rise_time <= cfg_data;
        REG_FALL_TIME: fall_time <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      target_level  <= '0;
      applied_level <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              target_level <= (in_target > max_duty) ? max_duty : in_target;
            end
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (hold || ramp_sel == '0) begin
            state <= ST_APPLY;
          end else begin
            state <= ST_START;
          end
        end
        ST_START: state <= ST_WAIT;
        ST_WAIT: begin
          if (div_stat.done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (out_free) begin
            applied_level <= applied_next;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_APPLY && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      dt   <= (in_elapsed > ELAP_W'(DT_LIMIT)) ? DT_LIMIT : in_elapsed[DT_W-1:0];
      hold <= in_elapsed == '0;
    end
    if (state == ST_MUL) begin
      prod      <= PROD_W'(max_duty) * PROD_W'(dt);
      ramp      <= ramp_sel;
      rising    <= rising_now;
      full_step <= ramp_sel == '0;
    end
    if (state == ST_APPLY && out_free) begin
      m_tdata <= applied_next;
    end
  end

  a_applied_only_in_update: assert property (@(posedge clk) disable iff (rst)
    (state != ST_APPLY) |=> applied_level == $past(applied_level))
    else $error("applied duty changed outside the update cycle");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata == applied_level)
    else $error("result word differs from applied duty");

  a_divider_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    (div_stat.busy || div_stat.done) |-> state == ST_WAIT)
    else $error("divider active outside its wait state");

endmodule

`default_nettype wire
